### src/tzr_pkg.sv
// Shared types and constants for the triangle z-buffer rasterizer.
`default_nettype none
package tzr_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_FAR    = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_READ_WAIT,
        ST_RECIP,
        ST_BOX,
        ST_SETUP,
        ST_ORIENT,
        ST_PIXEL,
        ST_WEIGHT,
        ST_SUM,
        ST_DEPTH,
        ST_WRITE,
        ST_NEXT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] vx0;
        logic signed [15:0] vy0;
        logic [23:0]        vd0;
        logic signed [15:0] vx1;
        logic signed [15:0] vy1;
        logic [23:0]        vd1;
        logic signed [15:0] vx2;
        logic signed [15:0] vy2;
        logic [23:0]        vd2;
        logic [7:0]         read_col;
        logic [7:0]         read_row;
    } t_in_req;

    typedef struct packed {
        logic [23:0] read_depth;
        logic [16:0] covered_pixels;
    } t_out_rsp;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [63:0] RECIP_NUM = 64'h0000_0100_0000_0000;
    localparam logic [63:0] DEPTH_NUM = 64'h0100_0000_0000_0000;
    localparam logic [2:0]  MUL_STEPS = 3'd6;
    localparam logic [2:0]  LAST_VTX  = 3'd2;

endpackage
`default_nettype wire

### src/tzr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tzr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### src/tzr_div.sv
// Restoring radix-2 divider, 64-bit dividend and divisor, one bit per cycle.
`default_nettype none
module tzr_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tzr_pkg::t_div_req i_req,
    output tzr_pkg::t_div_rsp      o_rsp
);
    import tzr_pkg::*;

    logic [63:0] r_num;
    logic [63:0] r_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] rem_sh;
    logic        q_bit;

    // dividend shifts out the top while quotient bits shift in at the bottom
    assign rem_sh = {r_rem, r_num[63]};
    assign q_bit  = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= q_bit ? 64'(rem_sh - {1'b0, r_den}) : rem_sh[63:0];
            r_num <= {r_num[62:0], q_bit};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;
endmodule
`default_nettype wire

### src/triangle_zbuffer_rasterizer_core.sv
// Top level: z-buffer triangle rasterizer with depth store, sequencer and APB registers.
// Draw: three reciprocal divisions, then setup, then each pixel of the box is tested; a pixel
// inside the triangle takes four 64-step divisions on the shared divider.
// One request at a time; input ready only in idle. Synchronous active-low reset restores
// the registers to 256/256/256000; the depth store is undefined until a clear.
`default_nettype none
module triangle_zbuffer_rasterizer_core #(
    parameter int MAX_DIM    = 256,
    parameter int DEPTH_BITS = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire tzr_pkg::t_in_req i_req,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output tzr_pkg::t_out_rsp     o_rsp,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready
);
    import tzr_pkg::*;

    localparam int DIM_BITS = $clog2(MAX_DIM);
    localparam int AW       = 2 * DIM_BITS;
    localparam int EW       = DIM_BITS + 1;
    localparam logic [63:0] DMAX64 = (64'd1 << DEPTH_BITS) - 64'd1;
    localparam logic [31:0] DMAX32 = 32'(DMAX64);

    // ---------------- configuration registers ----------------
    logic [8:0]  r_img_w, r_img_h;
    logic [23:0] r_far;
    t_reg_idx    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 9'd256;
            r_img_h <= 9'd256;
            r_far   <= 24'd256000;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_WIDTH:  r_img_w <= pwdata[8:0];
                REG_HEIGHT: r_img_h <= pwdata[8:0];
                REG_FAR:    r_far   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = {23'd0, r_img_w};
            REG_HEIGHT: prdata = {23'd0, r_img_h};
            REG_FAR:    prdata = {8'd0, r_far};
            default:    prdata = '0;
        endcase
    end

    // effective image size, clipped to the store
    logic [EW-1:0] w_eff, h_eff;
    assign w_eff = (32'(r_img_w) > 32'(MAX_DIM)) ? EW'(MAX_DIM) : EW'(r_img_w);
    assign h_eff = (32'(r_img_h) > 32'(MAX_DIM)) ? EW'(MAX_DIM) : EW'(r_img_h);

    logic [DEPTH_BITS-1:0] far_sat;
    assign far_sat = (32'(r_far) > DMAX32) ? DEPTH_BITS'(DMAX64) : DEPTH_BITS'(r_far);

    // ---------------- sequencer registers ----------------
    t_state  r_state, n_state;
    t_in_req r_req;
    logic [2:0] r_k;
    logic       r_go;
    logic       r_out_valid;
    t_out_rsp   r_rsp;

    logic [AW-1:0]       r_addr;      // clear sweep
    logic [DIM_BITS-1:0] r_col, r_row, r_cx0, r_cx1, r_cy1;
    logic                r_empty;
    logic                r_rd_ok;
    logic [16:0]         r_count;
    logic [23:0]         r_rd;

    logic [40:0] r_recip [3];
    logic [16:0] r_w     [3];
    logic signed [39:0] r_den, r_nv, r_nu, r_nv_row, r_nu_row;
    logic signed [39:0] r_cs_v, r_cs_u, r_rs_v, r_rs_u;   // column / row steps
    logic signed [43:0] r_prod;
    logic [63:0]        r_s;
    logic [DEPTH_BITS-1:0] r_depth;

    // ---------------- shared units ----------------
    t_div_req div_req;
    t_div_rsp div_rsp;

    tzr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [DEPTH_BITS-1:0] ram_wdata, ram_rdata;

    tzr_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (MAX_DIM * MAX_DIM)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------- geometry (combinational from held request) ----------------
    logic signed [16:0] e1x, e1y, e2x, e2y;
    assign e1x = 17'(r_req.vx1) - 17'(r_req.vx0);
    assign e1y = 17'(r_req.vy1) - 17'(r_req.vy0);
    assign e2x = 17'(r_req.vx2) - 17'(r_req.vx0);
    assign e2y = 17'(r_req.vy2) - 17'(r_req.vy0);

    logic signed [15:0] minx, maxx, miny, maxy;
    always_comb begin
        minx = (r_req.vx0 < r_req.vx1) ? r_req.vx0 : r_req.vx1;
        minx = (minx < r_req.vx2) ? minx : r_req.vx2;
        maxx = (r_req.vx0 > r_req.vx1) ? r_req.vx0 : r_req.vx1;
        maxx = (maxx > r_req.vx2) ? maxx : r_req.vx2;
        miny = (r_req.vy0 < r_req.vy1) ? r_req.vy0 : r_req.vy1;
        miny = (miny < r_req.vy2) ? miny : r_req.vy2;
        maxy = (r_req.vy0 > r_req.vy1) ? r_req.vy0 : r_req.vy1;
        maxy = (maxy > r_req.vy2) ? maxy : r_req.vy2;
    end

    // integer box: floor(v/16) is an arithmetic shift, then clip to the image
    logic signed [13:0] bx0, bx1, by0, by1, wm1, hm1;
    always_comb begin
        wm1 = $signed(14'(w_eff)) - 14'sd1;
        hm1 = $signed(14'(h_eff)) - 14'sd1;
        bx0 = 14'(minx >>> 4);
        by0 = 14'(miny >>> 4);
        bx1 = 14'(maxx >>> 4) + 14'sd1;
        by1 = 14'(maxy >>> 4) + 14'sd1;
        if (bx0 < 14'sd0) bx0 = '0;
        if (by0 < 14'sd0) by0 = '0;
        if (bx1 > wm1) bx1 = wm1;
        if (by1 > hm1) by1 = hm1;
    end

    // offset of the first pixel centre from vertex 0
    logic signed [18:0] px0, py0;
    assign px0 = $signed(19'({r_cx0, 4'd8})) - 19'(r_req.vx0);
    assign py0 = $signed(19'({r_row, 4'd8})) - 19'(r_req.vy0);

    logic signed [39:0] nw;
    logic               in_tri;
    assign nw     = r_den - r_nu - r_nv;
    assign in_tri = (r_nu >= 40'sd0) && (r_nv >= 40'sd0) && (nw >= 40'sd0);

    logic last_col, last_row;
    assign last_col = (r_col == r_cx1);
    assign last_row = (r_row == r_cy1);

    // ---------------- shared multiplier operand select ----------------
    logic signed [21:0] mul_a, mul_b;
    logic [1:0]         vtx;
    assign vtx = r_k[2:1];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == ST_SETUP) begin
            unique case (r_k)
                3'd0: begin mul_a = 22'(e1x); mul_b = 22'(e2y); end
                3'd1: begin mul_a = 22'(e1y); mul_b = 22'(e2x); end
                3'd2: begin mul_a = 22'(px0); mul_b = 22'(e2y); end
                3'd3: begin mul_a = 22'(py0); mul_b = 22'(e2x); end
                3'd4: begin mul_a = 22'(e1x); mul_b = 22'(py0); end
                3'd5: begin mul_a = 22'(e1y); mul_b = 22'(px0); end
                default: ;
            endcase
        end else if (r_state == ST_SUM && r_k < MUL_STEPS) begin
            // weight times low or high part of the reciprocal
            mul_a = $signed({5'd0, r_w[vtx]});
            mul_b = r_k[0] ? $signed({2'd0, r_recip[vtx][40:21]})
                           : $signed({1'b0, r_recip[vtx][20:0]});
        end
    end

    // ---------------- divider and store control ----------------
    logic [39:0] wnum;
    logic [23:0] vd_sel;
    always_comb begin
        unique case (r_k)
            3'd0:    wnum = nw;
            3'd1:    wnum = r_nv;
            default: wnum = r_nu;
        endcase
        unique case (r_k)
            3'd0:    vd_sel = r_req.vd0;
            3'd1:    vd_sel = r_req.vd1;
            default: vd_sel = r_req.vd2;
        endcase
    end

    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        ram_we        = 1'b0;
        ram_waddr     = {r_row, r_col};
        ram_wdata     = r_depth;
        ram_raddr     = {r_row, r_col};
        unique case (r_state)
            ST_RECIP: begin
                div_req.start = r_go;
                div_req.num   = RECIP_NUM;
                div_req.den   = (vd_sel == '0) ? 64'd1 : 64'(vd_sel);
            end
            ST_WEIGHT: begin
                div_req.start = r_go;
                div_req.num   = (64'(wnum) << 16) + 64'(r_den >>> 1);
                div_req.den   = 64'(r_den);
            end
            ST_DEPTH: begin
                // divisor of zero yields all ones, which saturates below
                div_req.start = r_go;
                div_req.num   = DEPTH_NUM + (r_s >> 1);
                div_req.den   = r_s;
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = far_sat;
            end
            ST_READ: begin
                ram_raddr = {DIM_BITS'(r_req.read_row), DIM_BITS'(r_req.read_col)};
            end
            ST_WRITE: begin
                ram_we = (r_depth < ram_rdata);
            end
            default: ;
        endcase
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_op'(i_req.op))
                        OP_CLEAR: n_state = ST_CLEAR;
                        OP_DRAW:  n_state = ST_RECIP;
                        OP_READ:  n_state = ST_READ;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:     if (&r_addr) n_state = ST_DONE;
            ST_READ:      n_state = ST_READ_WAIT;
            ST_READ_WAIT: n_state = ST_DONE;
            ST_RECIP:     if (div_rsp.done && r_k == LAST_VTX) n_state = ST_BOX;
            ST_BOX:       n_state = ST_SETUP;
            ST_SETUP:     if (r_k == MUL_STEPS) n_state = ST_ORIENT;
            ST_ORIENT:    n_state = (r_den == '0 || r_empty) ? ST_DONE : ST_PIXEL;
            ST_PIXEL:     n_state = in_tri ? ST_WEIGHT : ST_NEXT;
            ST_WEIGHT:    if (div_rsp.done && r_k == LAST_VTX) n_state = ST_SUM;
            ST_SUM:       if (r_k == MUL_STEPS) n_state = ST_DEPTH;
            ST_DEPTH:     if (div_rsp.done) n_state = ST_WRITE;
            ST_WRITE:     n_state = ST_NEXT;
            ST_NEXT:      n_state = (last_col && last_row) ? ST_DONE : ST_PIXEL;
            ST_DONE:      if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_rsp;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_go        <= 1'b0;
            r_k         <= '0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (r_state == ST_DONE && n_state == ST_IDLE) r_out_valid <= 1'b1;
            if (div_req.start) r_go <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_k  <= '0;
                    r_go <= 1'b1;
                end
                // arm the first weight division of every pixel
                ST_PIXEL: r_go <= 1'b1;
                ST_RECIP, ST_WEIGHT: begin
                    if (div_rsp.done) begin
                        r_k  <= (r_k == LAST_VTX) ? 3'd0 : r_k + 3'd1;
                        r_go <= 1'b1;
                    end
                end
                ST_SETUP, ST_SUM: begin
                    r_k <= (r_k == MUL_STEPS) ? 3'd0 : r_k + 3'd1;
                end
                default: ;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            ST_IDLE: begin
                r_req   <= i_req;
                r_addr  <= '0;
                r_count <= '0;
                r_rd    <= '0;
            end
            ST_CLEAR: r_addr <= r_addr + AW'(1);
            ST_READ: begin
                r_rd_ok <= ({24'd0, r_req.read_col} < 32'(w_eff))
                        && ({24'd0, r_req.read_row} < 32'(h_eff));
            end
            ST_READ_WAIT: r_rd <= r_rd_ok ? 24'(ram_rdata) : 24'd0;
            ST_RECIP: if (div_rsp.done) r_recip[r_k[1:0]] <= div_rsp.quot[40:0];
            ST_BOX: begin
                r_empty <= (bx0 > bx1) || (by0 > by1);
                r_cx0   <= DIM_BITS'(bx0);
                r_col   <= DIM_BITS'(bx0);
                r_cx1   <= DIM_BITS'(bx1);
                r_row   <= DIM_BITS'(by0);
                r_cy1   <= DIM_BITS'(by1);
            end
            ST_SETUP: begin
                unique case (r_k)
                    3'd1: r_den <= 40'(r_prod);
                    3'd2: r_den <= r_den - 40'(r_prod);
                    3'd3: r_nv  <= 40'(r_prod);
                    3'd4: r_nv  <= r_nv - 40'(r_prod);
                    3'd5: r_nu  <= 40'(r_prod);
                    3'd6: r_nu  <= r_nu - 40'(r_prod);
                    default: ;
                endcase
            end
            ST_ORIENT: begin
                // clockwise triangles: flip every edge value and step
                if (r_den < 40'sd0) begin
                    r_den    <= -r_den;
                    r_nv     <= -r_nv;
                    r_nu     <= -r_nu;
                    r_nv_row <= -r_nv;
                    r_nu_row <= -r_nu;
                    r_cs_v   <= -(40'(e2y) <<< 4);
                    r_cs_u   <= (40'(e1y) <<< 4);
                    r_rs_v   <= (40'(e2x) <<< 4);
                    r_rs_u   <= -(40'(e1x) <<< 4);
                end else begin
                    r_nv_row <= r_nv;
                    r_nu_row <= r_nu;
                    r_cs_v   <= (40'(e2y) <<< 4);
                    r_cs_u   <= -(40'(e1y) <<< 4);
                    r_rs_v   <= -(40'(e2x) <<< 4);
                    r_rs_u   <= (40'(e1x) <<< 4);
                end
            end
            ST_PIXEL: begin
                if (in_tri && r_count != COUNT_MAX) r_count <= r_count + 17'd1;
                r_s <= '0;
            end
            ST_WEIGHT: if (div_rsp.done) r_w[r_k[1:0]] <= div_rsp.quot[16:0];
            ST_SUM: begin
                if (r_k != 3'd0) begin
                    // previous step was a high part when r_k is even
                    r_s <= r_k[0] ? r_s + 64'(r_prod) : r_s + (64'(r_prod) << 21);
                end
            end
            ST_DEPTH: begin
                if (div_rsp.done) begin
                    r_depth <= (div_rsp.quot > DMAX64) ? DEPTH_BITS'(DMAX64)
                                                       : DEPTH_BITS'(div_rsp.quot);
                end
            end
            ST_NEXT: begin
                if (!last_col) begin
                    r_col <= r_col + DIM_BITS'(1);
                    r_nv  <= r_nv + r_cs_v;
                    r_nu  <= r_nu + r_cs_u;
                end else begin
                    r_col    <= r_cx0;
                    r_row    <= r_row + DIM_BITS'(1);
                    r_nv_row <= r_nv_row + r_rs_v;
                    r_nu_row <= r_nu_row + r_rs_u;
                    r_nv     <= r_nv_row + r_rs_v;
                    r_nu     <= r_nu_row + r_rs_u;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    r_rsp.read_depth     <= r_rd;
                    r_rsp.covered_pixels <= r_count;
                end
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    // a result carries either a depth or a count, never both
    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rsp.read_depth == '0 || o_rsp.covered_pixels == '0))
        else $error("result carries both depth and count");

    // the store is only written during a clear sweep or a depth update
    a_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_CLEAR || r_state == ST_WRITE))
        else $error("store written outside clear or draw");

    // the divider is never restarted while it is still iterating
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // a fresh result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_rsp))
        else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire
